// ===== rtl/core/text_console_cursor_scroll_macros.svh =====
// ----------------------------------------------------------------------------
// Text console assertion macros
// Shared property forms for the console checkers, clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

// check cons in the same cycle as ante
`define TCCS_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("text console check failed");

// check cons from the cycle after ante
`define TCCS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("text console check failed");

`endif

// ===== rtl/core/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console package
// Word types, character codes, opcodes and the control/status structs
// shared by the console controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccs_pkg;

   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int COLOR_W  = 4;
   localparam int INDEX_W  = 11;
   localparam int COL_W    = 7;
   localparam int LINE_W   = 5;
   localparam int LOC_W    = 11;
   localparam int CELL_W   = 16;

   localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [CHAR_W-1:0]   char_code;
      logic [COLOR_W-1:0]  back_color;
      logic [COLOR_W-1:0]  fg_color;
      logic [INDEX_W-1:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]  cursor_column;
      logic [LINE_W-1:0] cursor_line;
      logic [LOC_W-1:0]  cursor_location;
      logic [CELL_W-1:0] cell_value;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic exec;
      logic clear_step;
      logic scroll_step;
      logic read_capture;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                scroll_need;
      logic                clear_last;
      logic                scroll_last;
   } dp_sts_type;

endpackage

// ===== rtl/core/tccs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console controller
// Sequences accept, execute, memory sweeps and result delivery, and owns
// both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccs_ctrl
   import tccs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_SCROLL = 3'd4;
   localparam logic [2:0] ST_CLEAR  = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_INIT: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            unique case (sts.opcode)
               OP_PUT:   state_in = sts.scroll_need ? ST_SCROLL : ST_DONE;
               OP_CLEAR: state_in = ST_CLEAR;
               OP_READ:  state_in = ST_READ;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_READ: begin
            cmd.read_capture = 1'b1;
            state_in         = ST_DONE;
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (sts.scroll_last) begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/tccs_dpath.sv =====
// ----------------------------------------------------------------------------
// Text console datapath
// Screen memory, cursor, sweep counter, item and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccs_dpath
   import tccs_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   output rsp_type     rsp_data,
   input  ctl_cmd_type cmd,
   output dp_sts_type  sts
);

   localparam int CELLS       = COLUMNS * ROWS;
   localparam int SHIFT_CELLS = (ROWS - 1) * COLUMNS;
   localparam int AW          = $clog2(CELLS);
   localparam int NW          = AW + 1;
   localparam int CW          = $clog2(COLUMNS);
   localparam int RW          = $clog2(ROWS);
   localparam int XW          = CW + 4;
   localparam int YW          = RW + 1;
   localparam int LW          = (AW + 1 > LOC_W) ? AW + 1 : LOC_W;

   logic [CELL_W-1:0] mem [CELLS];

   req_type           item_ff;
   rsp_type           rsp_ff;
   logic [CW-1:0]     col_ff;
   logic [RW-1:0]     row_ff;
   logic [NW-1:0]     cnt_ff;
   logic [CELL_W-1:0] rd_data_ff;
   logic [CELL_W-1:0] value_ff;

   logic [XW-1:0]     col_x;
   logic [YW-1:0]     row_x;
   logic [XW-1:0]     tab_sum;
   logic              wr_cell;
   logic              scroll_need;
   logic              is_print;
   logic [AW-1:0]     pos;
   logic [LW-1:0]     loc_w;
   logic [LW-1:0]     idx_w;
   logic              idx_ok;
   logic [NW-1:0]     cnt_m1;
   logic [NW-1:0]     src_w;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;

   assign is_print = (item_ff.char_code >= CH_SPACE) && !item_ff.char_code[CHAR_W-1];
   assign pos      = AW'(row_ff * COLUMNS + col_ff);
   assign loc_w    = LW'(row_ff * COLUMNS + col_ff);
   assign idx_w    = LW'(item_ff.cell_index);
   assign idx_ok   = idx_w < LW'(CELLS);
   assign cnt_m1   = cnt_ff - NW'(1);
   assign src_w    = cnt_ff + NW'(COLUMNS);

   // cursor motion of a put word
   always_comb begin
      col_x   = XW'(col_ff);
      row_x   = YW'(row_ff);
      tab_sum = XW'(col_ff) + XW'(8);
      wr_cell = 1'b0;
      case (item_ff.char_code)
         CH_BS: begin
            if (col_ff != '0) begin
               col_x = XW'(col_ff) - XW'(1);
            end
         end
         CH_TAB: begin
            col_x = {tab_sum[XW-1:3], 3'b000};
         end
         CH_CR: begin
            col_x = '0;
         end
         CH_LF: begin
            col_x = '0;
            row_x = row_x + YW'(1);
         end
         default: begin
            if (is_print) begin
               wr_cell = 1'b1;
               col_x   = col_x + XW'(1);
            end
         end
      endcase
      if (col_x >= XW'(COLUMNS)) begin
         col_x = '0;
         row_x = row_x + YW'(1);
      end
      scroll_need = (row_x >= YW'(ROWS));
      if (scroll_need) begin
         row_x = YW'(ROWS - 1);
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos;
      wr_data = {item_ff.back_color, item_ff.fg_color, item_ff.char_code};
      if (cmd.exec && item_ff.opcode == OP_PUT && wr_cell) begin
         wr_en = 1'b1;
      end else if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff[AW-1:0];
         wr_data = BLANK_CELL;
      end else if (cmd.scroll_step && cnt_ff != '0) begin
         wr_en   = 1'b1;
         wr_addr = cnt_m1[AW-1:0];
         wr_data = (cnt_ff <= NW'(SHIFT_CELLS)) ? rd_data_ff : BLANK_CELL;
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_w[AW-1:0];
      if (cmd.exec && item_ff.opcode == OP_READ && idx_ok) begin
         rd_en = 1'b1;
      end else if (cmd.scroll_step && cnt_ff < NW'(SHIFT_CELLS)) begin
         rd_en   = 1'b1;
         rd_addr = src_w[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (cmd.exec) begin
            cnt_ff <= '0;
            if (item_ff.opcode == OP_PUT) begin
               col_ff <= col_x[CW-1:0];
               row_ff <= row_x[RW-1:0];
            end else if (item_ff.opcode == OP_CLEAR) begin
               col_ff <= '0;
               row_ff <= '0;
            end
         end else if (cmd.clear_step || cmd.scroll_step) begin
            cnt_ff <= cnt_ff + NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff  <= req_data;
         value_ff <= '0;
      end else if (cmd.read_capture) begin
         value_ff <= idx_ok ? rd_data_ff : '0;
      end
      if (cmd.load_rsp) begin
         rsp_ff.cursor_column   <= COL_W'(col_ff);
         rsp_ff.cursor_line     <= LINE_W'(row_ff);
         rsp_ff.cursor_location <= loc_w[LOC_W-1:0];
         rsp_ff.cell_value      <= value_ff;
      end
   end

   assign rsp_data        = rsp_ff;
   assign sts.opcode      = item_ff.opcode;
   assign sts.scroll_need = scroll_need;
   assign sts.clear_last  = (cnt_ff == NW'(CELLS - 1));
   assign sts.scroll_last = (cnt_ff == NW'(CELLS));

endmodule

// ===== rtl/core/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// Text console with cursor and scrolling
// Character screen of COLUMNS x ROWS attribute/character cells with a
// cursor, control-code handling, scrolling, clear and cell read-back.
// ----------------------------------------------------------------------------
// Words are taken one at a time. A put word passes through accept, execute
// with the cell write, and the result register; a read word adds a state for
// the registered read of the screen memory. The screen memory has one
// write port, so a put that scrolls adds a sweep over every cell (one cell
// moved per cycle, then the bottom row blanked), and a clear word adds a
// sweep that blanks every cell. After reset a clearing pass blanks the
// screen before the first word is accepted.
// A finished result waits in an output register while the next word is taken.
`timescale 1ns / 1ps

module text_console_cursor_scroll
   import tccs_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   tccs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tccs_dpath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule

// ===== rtl/core/tccs_checker.sv =====
// ----------------------------------------------------------------------------
// Text console port checker
// Watches the top-level ports for handshake and cursor consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_cursor_scroll_macros.svh"

module tccs_checker
   import tccs_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic req_fire;
   logic req_stall;

   assign req_fire  = req_valid && req_ready;
   assign req_stall = req_valid && !req_ready;

   `TCCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `TCCS_ASSERT_NEXT(a_req_hold, req_stall, $stable(req_data))
   `TCCS_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_ready ##1 !req_ready)
   `TCCS_ASSERT_SAME(a_cursor_range, rsp_valid,
                     rsp_data.cursor_column < COLUMNS && rsp_data.cursor_line < ROWS)

endmodule

bind text_console_cursor_scroll tccs_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_checker (.*);

// ===== bench/tb_text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// Text console testbench
// Drives put, clear, read and unused words into the console and checks
// every result word against its table entry or a cycle-free model of the screen and cursor.
// A short table covers the edges first; bursts of text lines, line feeds,
// control codes, reads, noise and clears follow, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll;
   import tccs_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   localparam int WORD_TARGET  = 850;
   localparam int STEADY_FROM  = 400;
   localparam int STEADY_UNTIL = 550;
   localparam int STALL_LIMIT  = 12000;
   localparam int DRAIN_CYCLES = 40;

   localparam logic [OPCODE_W-1:0] OP_NONE    = 2'd3;
   localparam logic [CHAR_W-1:0]   CH_LAST    = 8'h7F;
   localparam rsp_type             NO_RSP     = '0;

   typedef struct packed {
      req_type    word;
      logic [6:0] repeats;
      logic       typed;
      rsp_type    want;
   } step_row_type;

   localparam int STEPS = 21;

   step_row_type steps [STEPS] = '{
      '{'{OP_READ,  8'h00,  4'h0, 4'h0, 11'd0},    7'd1,  1'b1, '{7'd0, 5'd0, 11'd0, BLANK_CELL}},
      '{'{OP_READ,  8'h00,  4'h0, 4'h0, 11'd1999}, 7'd1,  1'b1, '{7'd0, 5'd0, 11'd0, BLANK_CELL}},
      '{'{OP_READ,  8'h00,  4'h0, 4'h0, 11'd2047}, 7'd1,  1'b1, NO_RSP},
      '{'{OP_NONE,  8'hFF,  4'hF, 4'hF, 11'd2047}, 7'd1,  1'b1, NO_RSP},
      '{'{OP_PUT,   CH_BS,  4'h0, 4'h0, 11'd0},    7'd1,  1'b1, NO_RSP},
      '{'{OP_PUT,   8'h41,  4'hF, 4'hF, 11'd0},    7'd1,  1'b1, '{7'd1, 5'd0, 11'd1, 16'h0000}},
      '{'{OP_READ,  8'h00,  4'h0, 4'h0, 11'd0},    7'd1,  1'b1, '{7'd1, 5'd0, 11'd1, 16'hFF41}},
      '{'{OP_PUT,   CH_BS,  4'h0, 4'h0, 11'd0},    7'd1,  1'b1, NO_RSP},
      '{'{OP_PUT,   CH_TAB, 4'h0, 4'h0, 11'd0},    7'd1,  1'b1, '{7'd8, 5'd0, 11'd8, 16'h0000}},
      '{'{OP_PUT,   CH_LAST, 4'h0, 4'h0, 11'd0},   7'd1,  1'b1, '{7'd9, 5'd0, 11'd9, 16'h0000}},
      '{'{OP_PUT,   CH_SPACE, 4'h5, 4'hA, 11'd0},  7'd1,  1'b0, NO_RSP},
      '{'{OP_PUT,   8'h1F,  4'h3, 4'hC, 11'd0},    7'd1,  1'b0, NO_RSP},
      '{'{OP_PUT,   8'h80,  4'hF, 4'hF, 11'd0},    7'd1,  1'b0, NO_RSP},
      '{'{OP_PUT,   8'hFF,  4'hF, 4'hF, 11'd2047}, 7'd1,  1'b0, NO_RSP},
      '{'{OP_PUT,   CH_CR,  4'h0, 4'h0, 11'd0},    7'd1,  1'b1, NO_RSP},
      '{'{OP_PUT,   CH_LF,  4'h0, 4'h0, 11'd0},    7'd1,  1'b1, '{7'd0, 5'd1, 11'd80, 16'h0000}},
      '{'{OP_READ,  8'h00,  4'h0, 4'h0, 11'd8},    7'd1,  1'b1, '{7'd0, 5'd1, 11'd80, 16'h007F}},
      '{'{OP_PUT,   CH_TAB, 4'h0, 4'h0, 11'd0},    7'd10, 1'b0, NO_RSP},
      '{'{OP_CLEAR, 8'h00,  4'h0, 4'h0, 11'd0},    7'd1,  1'b1, NO_RSP},
      '{'{OP_READ,  8'h00,  4'h0, 4'h0, 11'd8},    7'd1,  1'b1, '{7'd0, 5'd0, 11'd0, BLANK_CELL}},
      '{'{OP_READ,  8'h00,  4'h0, 4'h0, 11'd2000}, 7'd1,  1'b1, NO_RSP}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [CELL_W-1:0] screen_image [CELLS];
   int unsigned       pen_col;
   int unsigned       pen_row;
   rsp_type           pending_reports [$];
   int                words_sent     = 0;
   int                mismatch_count = 0;
   int                stall_cycles   = 0;
   bit                steady         = 1'b0;

   text_console_cursor_scroll #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void blank_screen();
      for (int i = 0; i < CELLS; i++) screen_image[i] = BLANK_CELL;
      pen_col = 0;
      pen_row = 0;
   endfunction

   function automatic rsp_type console_after(req_type w);
      rsp_type r;
      r = '0;
      case (w.opcode)
         OP_PUT: begin
            if (w.char_code == CH_BS) begin
               if (pen_col > 0) pen_col--;
            end else if (w.char_code == CH_TAB) begin
               pen_col = (pen_col + 8) & ~32'd7;
            end else if (w.char_code == CH_CR) begin
               pen_col = 0;
            end else if (w.char_code == CH_LF) begin
               pen_col = 0;
               pen_row++;
            end else if (w.char_code >= CH_SPACE && w.char_code <= CH_LAST) begin
               screen_image[pen_row * COLUMNS + pen_col] =
                  {w.back_color, w.fg_color, w.char_code};
               pen_col++;
            end
            if (pen_col >= COLUMNS) begin
               pen_col = 0;
               pen_row++;
            end
            if (pen_row >= ROWS) begin
               for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                  screen_image[i] = screen_image[i + COLUMNS];
               for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                  screen_image[i] = BLANK_CELL;
               pen_row = ROWS - 1;
            end
         end
         OP_CLEAR: blank_screen();
         OP_READ: begin
            if (w.cell_index < CELLS) r.cell_value = screen_image[w.cell_index];
         end
         default: ;
      endcase
      r.cursor_column   = pen_col[COL_W-1:0];
      r.cursor_line     = pen_row[LINE_W-1:0];
      r.cursor_location = LOC_W'(pen_row * COLUMNS + pen_col);
      return r;
   endfunction

   function automatic req_type make_word(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                                         logic [INDEX_W-1:0] idx);
      req_type w;
      w.opcode     = op;
      w.char_code  = ch;
      w.back_color = COLOR_W'($urandom_range(15));
      w.fg_color   = COLOR_W'($urandom_range(15));
      w.cell_index = idx;
      return w;
   endfunction

   task automatic send_word(input req_type w, input bit typed, input rsp_type want);
      rsp_type predicted;
      steady = (words_sent >= STEADY_FROM && words_sent < STEADY_UNTIL);
      while (!steady && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = console_after(w);
      pending_reports.push_back(typed ? want : predicted);
      words_sent++;
   endtask

   task automatic send_checked(input req_type w);
      send_word(w, 1'b0, NO_RSP);
   endtask

   task automatic run_burst();
      int unsigned pick;
      int unsigned count;
      int unsigned idx;
      logic [OPCODE_W-1:0] op;
      logic [CHAR_W-1:0]   ch;
      pick = $urandom_range(99);
      if (pick < 45) begin
         count = ($urandom_range(3) != 0) ? $urandom_range(12) : $urandom_range(100);
         repeat (count)
            send_checked(make_word(OP_PUT, CHAR_W'($urandom_range(CH_LAST, CH_SPACE)), 11'd0));
         pick = $urandom_range(9);
         if (pick >= 6 && pick < 8) send_checked(make_word(OP_PUT, CH_CR, 11'd0));
         if (pick < 8) send_checked(make_word(OP_PUT, CH_LF, 11'd0));
      end else if (pick < 65) begin
         repeat ($urandom_range(6, 1)) send_checked(make_word(OP_PUT, CH_LF, 11'd0));
      end else if (pick < 80) begin
         repeat ($urandom_range(4, 1)) begin
            pick = $urandom_range(9);
            if (pick < 5) idx = pen_row * COLUMNS + $urandom_range(COLUMNS - 1);
            else if (pick < 9) idx = $urandom_range(CELLS - 1);
            else idx = $urandom_range(2047, CELLS);
            send_checked(make_word(OP_READ, CHAR_W'($urandom_range(255)), INDEX_W'(idx)));
         end
      end else if (pick < 90) begin
         repeat ($urandom_range(8, 1)) begin
            case ($urandom_range(3))
               0: ch = CH_BS;
               1: ch = CH_TAB;
               2: ch = CH_CR;
               default: ch = CH_LF;
            endcase
            send_checked(make_word(OP_PUT, ch, INDEX_W'($urandom_range(2047))));
         end
      end else if (pick < 99) begin
         repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(2))
               0: op = OP_PUT;
               1: op = OP_NONE;
               default: op = OP_READ;
            endcase
            send_checked(make_word(op, CHAR_W'($urandom_range(255)),
                                   INDEX_W'($urandom_range(2047))));
         end
      end else begin
         send_checked(make_word(OP_CLEAR, CHAR_W'($urandom_range(255)),
                                INDEX_W'($urandom_range(2047))));
      end
   endtask

   task automatic compare_field(input string field, input logic [CELL_W-1:0] want,
                                input logic [CELL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected word, expected none actual %0h", $time, rsp_data);
            mismatch_count++;
         end else begin
            compare_field("cursor_column", CELL_W'(pending_reports[0].cursor_column),
                          CELL_W'(rsp_data.cursor_column));
            compare_field("cursor_line", CELL_W'(pending_reports[0].cursor_line),
                          CELL_W'(rsp_data.cursor_line));
            compare_field("cursor_location", CELL_W'(pending_reports[0].cursor_location),
                          CELL_W'(rsp_data.cursor_location));
            compare_field("cell_value", pending_reports[0].cell_value, rsp_data.cell_value);
            void'(pending_reports.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      blank_screen();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int s = 0; s < STEPS; s++)
         for (int k = 0; k < steps[s].repeats; k++)
            send_word(steps[s].word, steps[s].typed, steps[s].want);
      while (words_sent < WORD_TARGET) run_burst();
      req_valid <= 1'b0;
      steady = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
